@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and codes for the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_ERASE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // special character bytes
    localparam logic [7:0] CH_CLEAR   = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // attribute written with every put character
    localparam logic [7:0] TEXT_ATTR = 8'h07;

    // one screen cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

    // screen store strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

@@ rtl/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram
// screen cell store, one write and one registered read port
// ----------------------------------------------------------------------------
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  t_ram_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_cell             i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_cell             o_rd_data
);

    t_cell r_mem [DEPTH];
    t_cell r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/tcw_engine.sv @@
// ----------------------------------------------------------------------------
// tcw_engine
// cursor registers and sequencer for puts, erases, reads, scroll and clear
// ----------------------------------------------------------------------------
module tcw_engine
    import tcw_pkg::*;
#(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 25,
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int ROW_W   = $clog2(ROWS + 1),
    localparam int COL_W   = $clog2(COLUMNS + 1),
    localparam int ADDR_W  = $clog2(CELLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_char_code,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_col,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output t_cell             o_res_cell,
    output logic [ROW_W-1:0]  o_cur_row,
    output logic [COL_W-1:0]  o_cur_col,
    output t_ram_ctl          o_ram,
    output logic [ADDR_W-1:0] o_wr_addr,
    output t_cell             o_wr_data,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  t_cell             i_rd_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_after, n_after;
    logic              r_copy, n_copy;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_wr_pend, n_wr_pend;
    logic              r_wr_zero, n_wr_zero;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    t_cell             r_wdata, n_wdata;
    logic              r_adv, n_adv;

    logic              accept;
    logic              in_range;
    logic              new_line;
    logic              at_bottom;
    logic              sweep_bottom;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] in_addr;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign cur_addr = ADDR_W'(ADDR_W'(r_row) * ROW_STEP + ADDR_W'(r_col));
    assign in_addr  = ADDR_W'(ADDR_W'(i_row) * ROW_STEP + ADDR_W'(i_col));
    assign in_range = (i_row < ROW_W'(ROWS)) && (i_col < COL_W'(COLUMNS));

    // lazy wrap: a pending column past the edge behaves like a newline
    assign new_line     = (i_char_code == CH_NEWLINE) || (r_col >= COL_W'(COLUMNS));
    assign at_bottom    = (r_row == ROW_W'(ROWS - 1));
    assign sweep_bottom = (r_cnt >= BOTTOM_ROW);

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_copy      = r_copy;
        n_row       = r_row;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_wr_pend   = 1'b0;
        n_wr_zero   = r_wr_zero;
        n_wr_addr   = r_wr_addr;
        n_wdata     = r_wdata;
        n_adv       = r_adv;
        o_res_valid = 1'b0;
        o_res_cell  = '0;
        o_ram.re    = 1'b0;
        o_ram.we    = 1'b0;
        o_rd_addr   = ADDR_W'(r_cnt + ROW_STEP);
        o_wr_addr   = r_wr_addr;
        o_wr_data   = r_wr_zero ? t_cell'('0) : i_rd_data;

        // delayed sweep write, data arrives in the cycle after its read
        if (r_wr_pend) begin
            o_ram.we = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_PUT: begin
                            n_wdata = '{attr: TEXT_ATTR, ch: i_char_code};
                            n_adv   = 1'b1;
                            if (i_char_code == CH_CLEAR) begin
                                n_row   = '0;
                                n_col   = '0;
                                n_cnt   = '0;
                                n_copy  = 1'b0;
                                n_after = S_DONE;
                                n_state = S_SWEEP;
                            end else if (new_line) begin
                                n_col = '0;
                                if (at_bottom) begin
                                    n_cnt   = '0;
                                    n_copy  = 1'b1;
                                    n_after = (i_char_code == CH_NEWLINE) ? S_DONE : S_WRITE;
                                    n_state = S_SWEEP;
                                end else begin
                                    n_row   = ROW_W'(r_row + ROW_W'(1));
                                    n_state = (i_char_code == CH_NEWLINE) ? S_DONE : S_WRITE;
                                end
                            end else begin
                                n_state = S_WRITE;
                            end
                        end
                        OP_ERASE: begin
                            n_wdata = '0;
                            n_adv   = 1'b0;
                            if (r_row == '0 && r_col == '0) begin
                                n_state = S_DONE;
                            end else begin
                                if (r_col == '0) begin
                                    n_col = COL_W'(COLUMNS - 1);
                                    n_row = ROW_W'(r_row - ROW_W'(1));
                                end else begin
                                    n_col = COL_W'(r_col - COL_W'(1));
                                end
                                n_state = S_WRITE;
                            end
                        end
                        OP_READ: begin
                            if (in_range) begin
                                o_ram.re  = 1'b1;
                                o_rd_addr = in_addr;
                                n_state   = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                if (i_out_free) begin
                    o_ram.we    = 1'b1;
                    o_wr_addr   = cur_addr;
                    o_wr_data   = r_wdata;
                    n_col       = COL_W'(r_col + COL_W'(r_adv));
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    o_res_cell  = i_rd_data;
                    n_state     = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SWEEP: begin
                // copy rows up one and zero the bottom row, or zero everything when not copying
                o_ram.re  = r_copy && !sweep_bottom;
                n_wr_pend = 1'b1;
                n_wr_addr = r_cnt;
                n_wr_zero = !r_copy || sweep_bottom;
                if (r_cnt == LAST_CELL) begin
                    n_state = S_FLUSH;
                end else begin
                    n_cnt = ADDR_W'(r_cnt + ADDR_W'(1));
                end
            end
            S_FLUSH: begin
                n_state = r_after;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cur_row = n_row;
    assign o_cur_col = n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_after   <= S_IDLE;
            r_copy    <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_cnt     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_copy    <= n_copy;
            r_row     <= n_row;
            r_col     <= n_col;
            r_cnt     <= n_cnt;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_zero <= n_wr_zero;
        r_wr_addr <= n_wr_addr;
        r_wdata   <= n_wdata;
        r_adv     <= n_adv;
    end

endmodule

@@ rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell console engine with a screen store, cursor and scroll
// ----------------------------------------------------------------------------
// The screen lives in one single-port-write, registered-read memory of
// ROWS x COLUMNS cells (character low byte, attribute high byte). Every
// input word gives exactly one result word carrying the cursor after the
// operation and, for a read, the stored cell. A printable put or an erase
// is accepted and then writes its cell through the memory port, a read is
// accepted and then fetches the cell, and a newline that does not scroll,
// an erase at the home cell or an unused opcode only reports the cursor;
// the result waits while the output register is full. A put or newline
// that scrolls walks the whole store once, copying each row up and zeroing
// the bottom row; the character of a put is then written in the step that
// gives the result. A clear byte zeroes the whole store and homes the
// cursor. After reset the block sweeps the store to zero before it first
// raises o_in_ready. A finished result sits in the output register, so the
// next word can be accepted while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 25,
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int ROW_W   = $clog2(ROWS + 1),
    localparam int COL_W   = $clog2(COLUMNS + 1),
    localparam int ADDR_W  = $clog2(CELLS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input word channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_char_code,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    // result word channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_attr,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [COL_W-1:0] o_cursor_col
);

    // engine to store
    t_ram_ctl          ram_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    t_cell             wr_data;
    t_cell             rd_data;

    // engine result, taken only when the output register is free
    logic              res_valid;
    t_cell             res_cell;
    logic [ROW_W-1:0]  res_row;
    logic [COL_W-1:0]  res_col;
    logic              out_free;

    // output register
    logic              r_out_valid, n_out_valid;
    t_cell             r_out_cell;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res_cell  (res_cell),
        .o_cur_row   (res_row),
        .o_cur_col   (res_col),
        .o_ram       (ram_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_screen (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload only loads on a fresh result
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_cell <= res_cell;
            r_out_row  <= res_row;
            r_out_col  <= res_col;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_cell.ch;
    assign o_cell_attr  = r_out_cell.attr;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

`ifndef SYNTHESIS
    // a result must never overwrite one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || i_out_ready))
        else $error("result produced while output register full");

    // every accepted word takes the engine out of idle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("engine accepted a word back to back");

    // cursor row reported within the screen, column at most one past the last
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> ((res_row < ROW_W'(ROWS)) && (res_col <= COL_W'(COLUMNS))))
        else $error("cursor outside the screen");

    // a result given together with a write never carries cell data
    a_cell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && ram_ctl.we) |-> (res_cell == '0))
        else $error("cell data on a non-read result");
`endif

endmodule
